// ===== src/snr_pkg.sv =====
// Shared types, codes and helpers for the service name registry.
// No dependencies; used by snr_mem, snr_ctrl and service_name_registry.

package snr_pkg;

	// Request actions
	localparam logic [2:0] ACT_REGISTER = 3'd0;
	localparam logic [2:0] ACT_LOOKUP   = 3'd1;
	localparam logic [2:0] ACT_GATED    = 3'd2;
	localparam logic [2:0] ACT_UPDATE   = 3'd3;
	localparam logic [2:0] ACT_DEREG    = 3'd4;
	localparam logic [2:0] ACT_HEALTH   = 3'd5;

	// Result codes
	localparam logic [2:0] RC_OK        = 3'd0;
	localparam logic [2:0] RC_BAD_ARGS  = 3'd1;
	localparam logic [2:0] RC_DUPLICATE = 3'd2;
	localparam logic [2:0] RC_FULL      = 3'd3;
	localparam logic [2:0] RC_NOT_FOUND = 3'd4;
	localparam logic [2:0] RC_FORBIDDEN = 3'd5;
	localparam logic [2:0] RC_UNKNOWN   = 3'd6;

	localparam int unsigned NAME_W = 128;

	typedef struct packed {
		logic [2:0]  action;
		logic [63:0] name_high;
		logic [63:0] name_low;
		logic [31:0] channel;
		logic [31:0] domain_id;
		logic [31:0] class_mask;
		logic [31:0] service_version;
		logic [7:0]  upd_status;
		logic [15:0] allowed_classes;
	} req_t;

	typedef struct packed {
		logic [2:0]  result_code;
		logic [31:0] found_channel;
		logic [31:0] found_domain;
		logic [7:0]  found_status;
		logic [31:0] found_classes;
		logic [31:0] found_version;
		logic [6:0]  active_total;
	} rsp_t;

	// One table slot as held in memory
	typedef struct packed {
		logic              valid;
		logic [NAME_W-1:0] name;
		logic [31:0]       channel;
		logic [31:0]       domain;
		logic [31:0]       classes;
		logic [31:0]       version;
		logic [7:0]        status;
	} slot_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Zero every byte from the first zero byte on and every byte past nbytes
	function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] raw,
			input int unsigned nbytes);
		logic [NAME_W-1:0] res;
		logic              ended;
		logic [7:0]        b;
		res   = '0;
		ended = 1'b0;
		for (int unsigned i = 0; i < 16; i++) begin
			b = raw[NAME_W-1-8*i -: 8];
			if (ended || i >= nbytes) begin
				b = 8'h00;
			end
			if (b == 8'h00) begin
				ended = 1'b1;
			end
			res[NAME_W-1-8*i -: 8] = b;
		end
		return res;
	endfunction

endpackage

// ===== src/service_name_registry.sv =====
// Service name registry top level: sequencer, slot memory and result register.
// Depends on snr_pkg, snr_mem and snr_ctrl.
//
// A request is a transfer on start while busy is low. Every request scans all
// ENTRIES slots of the table memory, one read per cycle through its single
// read port, then decides the result and does the write-back in the DONE
// state: busy stays high through the scan and DONE, and the next request can
// be taken once busy is low again. The result appears on rsp with done high
// for exactly one cycle, starting at the edge where busy drops, and is taken
// at the following edge; the receiver cannot hold it off and must take it
// then. After reset the block sweeps every slot of the memory clear with busy
// high.

module service_name_registry #(
	parameter int unsigned ENTRIES    = 64,
	parameter int unsigned NAME_BYTES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  snr_pkg::req_t  req,
	output logic           done,
	output snr_pkg::rsp_t  rsp
);

	localparam int unsigned IW = $clog2(ENTRIES);

	logic            rd_en;
	logic [IW-1:0]   rd_addr;
	snr_pkg::slot_t  rd_data;
	logic            wr_en;
	logic [IW-1:0]   wr_addr;
	snr_pkg::slot_t  wr_data;
	logic            fin;
	snr_pkg::rsp_t   fin_rsp;
	logic            done_q;
	snr_pkg::rsp_t   rsp_q;

	snr_ctrl #(
		.ENTRIES    (ENTRIES),
		.NAME_BYTES (NAME_BYTES)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.busy    (busy),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.fin     (fin),
		.fin_rsp (fin_rsp)
	);

	snr_mem #(
		.ENTRIES (ENTRIES)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// Strobe the result for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin;
		end
	end

	// Hold the result fields
	always_ff @(posedge clk) begin
		if (fin) begin
			rsp_q <= fin_rsp;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== src/snr_mem.sv =====
// Slot table memory: one write port, one read port, registered read data.
// Depends on snr_pkg for the slot record type.

module snr_mem #(
	parameter int unsigned ENTRIES = 64,
	localparam int unsigned IW = $clog2(ENTRIES)
) (
	input  logic            clk,
	input  logic            rd_en,
	input  logic [IW-1:0]   rd_addr,
	output snr_pkg::slot_t  rd_data,
	input  logic            wr_en,
	input  logic [IW-1:0]   wr_addr,
	input  snr_pkg::slot_t  wr_data
);

	snr_pkg::slot_t ram_q [ENTRIES];
	snr_pkg::slot_t rd_data_q;

	// Write one slot
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ram_q[wr_addr] <= wr_data;
		end
	end

	// Read one slot into a registered output
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= ram_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/snr_ctrl.sv =====
// Request sequencer: clears the table after reset, scans all slots per request,
// then decides the result and writes back at most one slot. Depends on snr_pkg.

module snr_ctrl #(
	parameter int unsigned ENTRIES    = 64,
	parameter int unsigned NAME_BYTES = 16,
	localparam int unsigned IW = $clog2(ENTRIES),
	localparam int unsigned CW = $clog2(ENTRIES + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  snr_pkg::req_t   req,
	output logic            busy,
	output logic            rd_en,
	output logic [IW-1:0]   rd_addr,
	input  snr_pkg::slot_t  rd_data,
	output logic            wr_en,
	output logic [IW-1:0]   wr_addr,
	output snr_pkg::slot_t  wr_data,
	output logic            fin,
	output snr_pkg::rsp_t   fin_rsp
);

	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	snr_pkg::state_t state_q, state_nxt;

	snr_pkg::req_t                 req_q;
	logic [snr_pkg::NAME_W-1:0]    name_q;
	logic [IW-1:0]                 iss_q;
	logic                          iss_end_q;
	logic                          cmp_vld_s1;
	logic [IW-1:0]                 cmp_idx_s1;
	logic                          found_q;
	logic [IW-1:0]                 found_idx_q;
	snr_pkg::slot_t                found_rec_q;
	logic                          free_q;
	logic [IW-1:0]                 free_idx_q;
	logic [CW-1:0]                 cnt_q, cnt_nxt;
	logic [IW-1:0]                 clr_q;

	logic                          accept;
	logic                          by_name;
	logic                          hit;
	logic                          empty;
	logic [2:0]                    dec_rc;
	logic                          dec_show;
	logic                          dec_wr;
	logic [IW-1:0]                 dec_waddr;
	snr_pkg::slot_t                dec_wdata;

	assign accept  = (state_q == snr_pkg::ST_IDLE) && start;
	assign by_name = req_q.action inside {snr_pkg::ACT_REGISTER, snr_pkg::ACT_LOOKUP,
		snr_pkg::ACT_GATED};
	assign hit     = rd_data.valid && (by_name ? (rd_data.name == name_q)
		: (rd_data.channel == req_q.channel));
	assign empty   = (name_q[snr_pkg::NAME_W-1 -: 8] == 8'h00);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			snr_pkg::ST_CLEAR: begin
				if (clr_q == LAST) begin
					state_nxt = snr_pkg::ST_IDLE;
				end
			end
			snr_pkg::ST_IDLE: begin
				if (start) begin
					state_nxt = snr_pkg::ST_SCAN;
				end
			end
			snr_pkg::ST_SCAN: begin
				if (cmp_vld_s1 && (cmp_idx_s1 == LAST)) begin
					state_nxt = snr_pkg::ST_DONE;
				end
			end
			snr_pkg::ST_DONE: begin
				state_nxt = snr_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = snr_pkg::ST_IDLE;
			end
		endcase
	end

	// Decide the result and the write-back from the scan outcome
	always_comb begin
		dec_rc    = snr_pkg::RC_OK;
		dec_show  = 1'b0;
		dec_wr    = 1'b0;
		dec_waddr = found_idx_q;
		dec_wdata = found_rec_q;
		cnt_nxt   = cnt_q;
		case (req_q.action)
			snr_pkg::ACT_REGISTER: begin
				if (empty) begin
					dec_rc = snr_pkg::RC_BAD_ARGS;
				end else if (found_q) begin
					dec_rc = snr_pkg::RC_DUPLICATE;
				end else if (!free_q) begin
					dec_rc = snr_pkg::RC_FULL;
				end else begin
					dec_wr            = 1'b1;
					dec_waddr         = free_idx_q;
					dec_wdata.valid   = 1'b1;
					dec_wdata.name    = name_q;
					dec_wdata.channel = req_q.channel;
					dec_wdata.domain  = req_q.domain_id;
					dec_wdata.classes = req_q.class_mask;
					dec_wdata.version = req_q.service_version;
					dec_wdata.status  = 8'h00;
					cnt_nxt           = cnt_q + CW'(1);
				end
			end
			snr_pkg::ACT_LOOKUP, snr_pkg::ACT_GATED: begin
				if (empty) begin
					dec_rc = snr_pkg::RC_BAD_ARGS;
				end else if (!found_q) begin
					dec_rc = snr_pkg::RC_NOT_FOUND;
				end else if ((req_q.action == snr_pkg::ACT_GATED) &&
						((req_q.allowed_classes == 16'h0000) ||
						((found_rec_q.classes[15:0] & req_q.allowed_classes) == 16'h0000))) begin
					dec_rc = snr_pkg::RC_FORBIDDEN;
				end else begin
					dec_show = 1'b1;
				end
			end
			snr_pkg::ACT_UPDATE: begin
				if (!found_q) begin
					dec_rc = snr_pkg::RC_NOT_FOUND;
				end else begin
					dec_wr           = 1'b1;
					dec_wdata.status = req_q.upd_status;
				end
			end
			snr_pkg::ACT_DEREG: begin
				if (!found_q) begin
					dec_rc = snr_pkg::RC_NOT_FOUND;
				end else begin
					dec_wr          = 1'b1;
					dec_wdata.valid = 1'b0;
					if (cnt_q != '0) begin
						cnt_nxt = cnt_q - CW'(1);
					end
				end
			end
			snr_pkg::ACT_HEALTH: begin
				dec_rc = snr_pkg::RC_OK;
			end
			default: begin
				dec_rc = snr_pkg::RC_UNKNOWN;
			end
		endcase
	end

	// Outputs per state
	always_comb begin
		busy    = (state_q != snr_pkg::ST_IDLE);
		rd_en   = (state_q == snr_pkg::ST_SCAN) && !iss_end_q;
		rd_addr = iss_q;
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = '0;
		fin     = 1'b0;
		case (state_q)
			snr_pkg::ST_CLEAR: begin
				wr_en = 1'b1;
			end
			snr_pkg::ST_DONE: begin
				wr_en   = dec_wr;
				wr_addr = dec_waddr;
				wr_data = dec_wdata;
				fin     = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Assemble the result fields
	always_comb begin
		fin_rsp               = '0;
		fin_rsp.result_code   = dec_rc;
		fin_rsp.active_total  = 7'(cnt_nxt);
		if (dec_show) begin
			fin_rsp.found_channel = found_rec_q.channel;
			fin_rsp.found_domain  = found_rec_q.domain;
			fin_rsp.found_status  = found_rec_q.status;
			fin_rsp.found_classes = found_rec_q.classes;
			fin_rsp.found_version = found_rec_q.version;
		end
	end

	// Control state: phase, clear sweep, scan progress, match flags, count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= snr_pkg::ST_CLEAR;
			clr_q      <= '0;
			iss_q      <= '0;
			iss_end_q  <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
			free_q     <= 1'b0;
			cnt_q      <= '0;
		end else begin
			state_q    <= state_nxt;
			cmp_vld_s1 <= rd_en;
			if (state_q == snr_pkg::ST_CLEAR) begin
				clr_q <= clr_q + IW'(1);
			end
			if (accept) begin
				iss_q     <= '0;
				iss_end_q <= 1'b0;
				found_q   <= 1'b0;
				free_q    <= 1'b0;
			end else begin
				// Advance the read address
				if (rd_en) begin
					iss_q <= iss_q + IW'(1);
					if (iss_q == LAST) begin
						iss_end_q <= 1'b1;
					end
				end
				// Hold the first match and the first free slot
				if (cmp_vld_s1) begin
					if (hit && !found_q) begin
						found_q <= 1'b1;
					end
					if (!rd_data.valid && !free_q) begin
						free_q <= 1'b1;
					end
				end
			end
			if (state_q == snr_pkg::ST_DONE) begin
				cnt_q <= cnt_nxt;
			end
		end
	end

	// Payload captured with the transfer and during the scan
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req;
			name_q <= snr_pkg::canon_name({req.name_high, req.name_low}, NAME_BYTES);
		end
		cmp_idx_s1 <= iss_q;
		if (cmp_vld_s1 && hit && !found_q) begin
			found_idx_q <= cmp_idx_s1;
			found_rec_q <= rd_data;
		end
		if (cmp_vld_s1 && !rd_data.valid && !free_q) begin
			free_idx_q <= cmp_idx_s1;
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the service name registry: directed cases, a full-table pass
// and random request traffic, checked against a local model of the slot table.
// Depends on snr_pkg and service_name_registry.
`timescale 1ns / 1ps

module tb_top;

	localparam int SLOTS        = 64;
	localparam int NAME_LEN     = 16;
	localparam int POOL         = 80;
	localparam int CHANS        = 12;
	localparam int RANDOM_ITEMS = 1370;
	localparam int STALL_LIMIT  = 1000;

	// Reserved action codes, answered as unknown
	localparam logic [2:0] ACT_RSVD_6 = 3'd6;
	localparam logic [2:0] ACT_RSVD_7 = 3'd7;

	localparam logic [31:0] FILL_CHAN = 32'h5A00_0000;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	snr_pkg::req_t req;
	logic          done;
	snr_pkg::rsp_t rsp;

	service_name_registry #(
		.ENTRIES   (SLOTS),
		.NAME_BYTES(NAME_LEN)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	// Local copy of the slot table
	logic         slot_used [SLOTS];
	logic [127:0] slot_key  [SLOTS];
	logic [31:0]  slot_chan [SLOTS];
	logic [31:0]  slot_dom  [SLOTS];
	logic [31:0]  slot_cls  [SLOTS];
	logic [31:0]  slot_ver  [SLOTS];
	logic [7:0]   slot_stat [SLOTS];
	logic [6:0]   live_count;

	snr_pkg::rsp_t owed_replies[$];
	int            mismatch_count;
	bit            no_gaps;

	logic [127:0] pool_name [POOL];
	int           pool_len  [POOL];
	logic [31:0]  chan_pool [CHANS];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Keep the bytes before the first zero byte, at most NAME_LEN of them
	function automatic logic [127:0] name_key(input logic [63:0] hi, input logic [63:0] lo);
		logic [127:0] raw;
		logic [127:0] key;
		logic         ended;
		raw   = {hi, lo};
		key   = '0;
		ended = 1'b0;
		for (int n = 0; n < 16; n++) begin
			if (raw[127-8*n -: 8] == 8'h00 || n >= NAME_LEN) begin
				ended = 1'b1;
			end
			if (!ended) begin
				key[127-8*n -: 8] = raw[127-8*n -: 8];
			end
		end
		return key;
	endfunction

	function automatic int slot_by_key(input logic [127:0] key);
		for (int s = 0; s < SLOTS; s++) begin
			if (slot_used[s] && slot_key[s] == key) return s;
		end
		return -1;
	endfunction

	function automatic int slot_by_chan(input logic [31:0] ch);
		for (int s = 0; s < SLOTS; s++) begin
			if (slot_used[s] && slot_chan[s] == ch) return s;
		end
		return -1;
	endfunction

	// Apply one request to the local table and return the reply it owes
	function automatic snr_pkg::rsp_t registry_step(input snr_pkg::req_t r);
		snr_pkg::rsp_t want;
		logic [127:0]  key;
		int            hit;
		want = '0;
		want.result_code = snr_pkg::RC_OK;
		key  = name_key(r.name_high, r.name_low);
		case (r.action)
			snr_pkg::ACT_REGISTER: begin
				hit = slot_by_key(key);
				if (key[127:120] == 8'h00) begin
					want.result_code = snr_pkg::RC_BAD_ARGS;
				end else if (hit >= 0) begin
					want.result_code = snr_pkg::RC_DUPLICATE;
				end else begin
					for (int s = SLOTS - 1; s >= 0; s--) begin
						if (!slot_used[s]) hit = s;
					end
					if (hit < 0) begin
						want.result_code = snr_pkg::RC_FULL;
					end else begin
						slot_used[hit] = 1'b1;
						slot_key[hit]  = key;
						slot_chan[hit] = r.channel;
						slot_dom[hit]  = r.domain_id;
						slot_cls[hit]  = r.class_mask;
						slot_ver[hit]  = r.service_version;
						slot_stat[hit] = 8'h00;
						live_count     = live_count + 7'd1;
					end
				end
			end
			snr_pkg::ACT_LOOKUP, snr_pkg::ACT_GATED: begin
				hit = slot_by_key(key);
				if (key[127:120] == 8'h00) begin
					want.result_code = snr_pkg::RC_BAD_ARGS;
				end else if (hit < 0) begin
					want.result_code = snr_pkg::RC_NOT_FOUND;
				end else if (r.action == snr_pkg::ACT_GATED && (r.allowed_classes == 16'h0000 ||
						(slot_cls[hit][15:0] & r.allowed_classes) == 16'h0000)) begin
					want.result_code = snr_pkg::RC_FORBIDDEN;
				end else begin
					want.found_channel = slot_chan[hit];
					want.found_domain  = slot_dom[hit];
					want.found_status  = slot_stat[hit];
					want.found_classes = slot_cls[hit];
					want.found_version = slot_ver[hit];
				end
			end
			snr_pkg::ACT_UPDATE: begin
				hit = slot_by_chan(r.channel);
				if (hit < 0) begin
					want.result_code = snr_pkg::RC_NOT_FOUND;
				end else begin
					slot_stat[hit] = r.upd_status;
				end
			end
			snr_pkg::ACT_DEREG: begin
				hit = slot_by_chan(r.channel);
				if (hit < 0) begin
					want.result_code = snr_pkg::RC_NOT_FOUND;
				end else begin
					slot_used[hit] = 1'b0;
					if (live_count != 7'd0) live_count = live_count - 7'd1;
				end
			end
			snr_pkg::ACT_HEALTH: begin
			end
			default: begin
				want.result_code = snr_pkg::RC_UNKNOWN;
			end
		endcase
		want.active_total = live_count;
		return want;
	endfunction

	// Pack a short text name, first character in the top byte
	function automatic logic [127:0] name_of(input string s);
		logic [127:0] key;
		key = '0;
		for (int n = 0; n < s.len() && n < 16; n++) begin
			key[127-8*n -: 8] = s[n];
		end
		return key;
	endfunction

	// Fill the bytes after the terminator with junk that must not matter
	function automatic logic [127:0] add_tail(input logic [127:0] key, input int len);
		logic [127:0] raw;
		raw = key;
		for (int n = len + 1; n < 16; n++) begin
			raw[127-8*n -: 8] = 8'($urandom_range(0, 255));
		end
		return raw;
	endfunction

	// Request with the given action, name and channel; other fields random
	function automatic snr_pkg::req_t make_req(input logic [2:0] act, input logic [127:0] raw,
			input logic [31:0] ch);
		snr_pkg::req_t r;
		r.action          = act;
		r.name_high       = raw[127:64];
		r.name_low        = raw[63:0];
		r.channel         = ch;
		r.domain_id       = $urandom;
		r.class_mask      = $urandom;
		r.service_version = $urandom;
		r.upd_status      = 8'($urandom_range(0, 255));
		r.allowed_classes = 16'($urandom_range(0, 65535));
		return r;
	endfunction

	// Transfer one request; the gap counts idle cycles after busy drops
	task automatic send_req(input snr_pkg::req_t r);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			start <= 1'b0;
			do @(posedge clk); while (busy);
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
		owed_replies.push_back(registry_step(r));
	endtask

	task automatic send_act(input logic [2:0] act, input logic [127:0] raw,
			input logic [31:0] ch);
		send_req(make_req(act, raw, ch));
	endtask

	task automatic build_pools();
		logic [127:0] key;
		int           len;
		bit           fresh;
		for (int p = 0; p < POOL; p++) begin
			do begin
				len = ($urandom_range(0, 3) == 0) ? 16 : $urandom_range(1, 15);
				key = '0;
				for (int n = 0; n < len; n++) begin
					key[127-8*n -: 8] = 8'($urandom_range(1, 255));
				end
				fresh = 1'b1;
				for (int q = 0; q < p; q++) begin
					if (pool_name[q] == key) fresh = 1'b0;
				end
			end while (!fresh);
			pool_name[p] = key;
			pool_len[p]  = len;
		end
		chan_pool[0] = 32'h0000_0000;
		chan_pool[1] = 32'hFFFF_FFFF;
		for (int c = 2; c < CHANS; c++) begin
			chan_pool[c] = $urandom;
		end
	endtask

	// Extremes of the fields and every special case of each action but a full table
	task automatic test_directed_cases();
		snr_pkg::req_t r;
		logic [127:0]  all_ones;
		all_ones = '1;
		send_act(snr_pkg::ACT_HEALTH, '0, 32'h0);
		send_act(snr_pkg::ACT_LOOKUP, name_of("svc"), 32'h0);
		// empty names carry junk that the terminator hides
		send_act(snr_pkg::ACT_REGISTER, add_tail('0, 0), 32'h1);
		send_act(snr_pkg::ACT_LOOKUP, add_tail('0, 0), 32'h1);
		send_act(snr_pkg::ACT_GATED, add_tail('0, 0), 32'h1);
		r = make_req(snr_pkg::ACT_REGISTER, all_ones, 32'hFFFF_FFFF);
		r.domain_id       = 32'hFFFF_FFFF;
		r.class_mask      = 32'hFFFF_FFFF;
		r.service_version = 32'hFFFF_FFFF;
		r.upd_status      = 8'hFF;
		r.allowed_classes = 16'hFFFF;
		send_req(r);
		send_act(snr_pkg::ACT_REGISTER, all_ones, 32'h0000_0042);
		r = make_req(snr_pkg::ACT_REGISTER, add_tail(name_of("x"), 1), 32'h0);
		r.domain_id       = 32'h0;
		r.class_mask      = 32'h0;
		r.service_version = 32'h0;
		r.upd_status      = 8'h00;
		r.allowed_classes = 16'h0000;
		send_req(r);
		// shares channel 0 with the entry above; classes only in the upper half
		r = make_req(snr_pkg::ACT_REGISTER, name_of("x-ray"), 32'h0);
		r.class_mask = 32'h0001_0000;
		send_req(r);
		send_act(snr_pkg::ACT_LOOKUP, add_tail(name_of("x"), 1), 32'h0);
		send_act(snr_pkg::ACT_LOOKUP, all_ones, 32'h0);
		r = make_req(snr_pkg::ACT_GATED, all_ones, 32'h0);
		r.allowed_classes = 16'h0000;
		send_req(r);
		r = make_req(snr_pkg::ACT_GATED, all_ones, 32'h0);
		r.allowed_classes = 16'hFFFF;
		send_req(r);
		r = make_req(snr_pkg::ACT_GATED, name_of("x-ray"), 32'h0);
		r.allowed_classes = 16'hFFFF;
		send_req(r);
		send_act(snr_pkg::ACT_GATED, name_of("nobody"), 32'h0);
		// update and deregister hit the lowest slot of a shared channel
		r = make_req(snr_pkg::ACT_UPDATE, '0, 32'h0);
		r.upd_status = 8'hFF;
		send_req(r);
		send_act(snr_pkg::ACT_LOOKUP, name_of("x"), 32'h0);
		send_act(snr_pkg::ACT_LOOKUP, name_of("x-ray"), 32'h0);
		send_act(snr_pkg::ACT_UPDATE, '0, 32'h0000_3039);
		send_act(snr_pkg::ACT_DEREG, '0, 32'h0);
		send_act(snr_pkg::ACT_LOOKUP, name_of("x"), 32'h0);
		send_act(snr_pkg::ACT_DEREG, '0, 32'h7777_7777);
		send_act(ACT_RSVD_6, name_of("svc"), 32'h0);
		send_act(ACT_RSVD_7, all_ones, 32'hFFFF_FFFF);
		send_act(snr_pkg::ACT_HEALTH, '0, 32'h0);
	endtask

	// Fill every slot, overflow, free half, refill ten of the holes, then empty it
	task automatic test_table_full();
		snr_pkg::req_t r;
		no_gaps = 1'b1;
		for (int s = 0; s < SLOTS; s++) begin
			send_act(snr_pkg::ACT_REGISTER, add_tail(pool_name[s], pool_len[s]), FILL_CHAN + s);
			if (s == SLOTS / 2) no_gaps = 1'b0;
		end
		send_act(snr_pkg::ACT_REGISTER, pool_name[SLOTS], FILL_CHAN + SLOTS);
		send_act(snr_pkg::ACT_REGISTER, add_tail(pool_name[3], pool_len[3]), FILL_CHAN);
		send_act(snr_pkg::ACT_HEALTH, '0, 32'h0);
		for (int s = 1; s < SLOTS; s += 2) begin
			send_act(snr_pkg::ACT_DEREG, '0, FILL_CHAN + s);
		end
		for (int s = 0; s < 10; s++) begin
			send_act(snr_pkg::ACT_REGISTER, pool_name[SLOTS + s], FILL_CHAN + SLOTS + s);
		end
		for (int s = 0; s < 10; s++) begin
			send_act(snr_pkg::ACT_LOOKUP, add_tail(pool_name[s], pool_len[s]), 32'h0);
			r = make_req(snr_pkg::ACT_GATED, pool_name[SLOTS + s], 32'h0);
			r.allowed_classes = 16'h0001 << $urandom_range(0, 15);
			send_req(r);
		end
		for (int s = 0; s < SLOTS + 10; s++) begin
			send_act(snr_pkg::ACT_DEREG, '0, FILL_CHAN + s);
		end
		send_act(snr_pkg::ACT_DEREG, '0, 32'h0);
		send_act(snr_pkg::ACT_DEREG, '0, 32'hFFFF_FFFF);
		send_act(snr_pkg::ACT_HEALTH, '0, 32'h0);
	endtask

	// Mostly well-formed traffic on pooled names and channels, some noise
	task automatic test_random_traffic();
		snr_pkg::req_t r;
		logic [127:0]  raw;
		logic [31:0]   ch;
		int            pick;
		int            p;
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			p    = $urandom_range(0, POOL - 1);
			raw  = $urandom_range(0, 1) ? add_tail(pool_name[p], pool_len[p]) : pool_name[p];
			ch   = ($urandom_range(0, 6) != 0) ? chan_pool[$urandom_range(0, CHANS - 1)]
				: $urandom;
			r = make_req(snr_pkg::ACT_REGISTER, raw, ch);
			if (pick < 30) begin
				if ($urandom_range(0, 6) == 0) r.class_mask[15:0] = 16'h0000;
			end else if (pick < 50) begin
				r.action = snr_pkg::ACT_LOOKUP;
				if ($urandom_range(0, 11) == 0) begin
					r.name_high = {$urandom, $urandom};
					r.name_low  = {$urandom, $urandom};
				end
			end else if (pick < 65) begin
				r.action = snr_pkg::ACT_GATED;
				case ($urandom_range(0, 9))
					0:       r.allowed_classes = 16'h0000;
					1, 2, 3: r.allowed_classes = 16'h0001 << $urandom_range(0, 15);
					default: ;
				endcase
			end else if (pick < 75) begin
				r.action = snr_pkg::ACT_UPDATE;
			end else if (pick < 89) begin
				r.action = snr_pkg::ACT_DEREG;
			end else if (pick < 93) begin
				r.action = snr_pkg::ACT_HEALTH;
			end else if (pick < 96) begin
				// empty name on a name-keyed action
				r.action = 3'(snr_pkg::ACT_LOOKUP - $urandom_range(0, 1) + $urandom_range(0, 1));
				r.name_high[63:56] = 8'h00;
			end else begin
				r.action = $urandom_range(0, 1) ? ACT_RSVD_6 : ACT_RSVD_7;
			end
			send_req(r);
		end
		no_gaps = 1'b0;
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
		end
	endtask

	// Check each reply against the oldest owed one
	always @(posedge clk) begin : rsp_check
		snr_pkg::rsp_t want;
		if (arst_n && done) begin
			if (owed_replies.size() == 0) begin
				mismatch_count++;
				$error("reply with no request outstanding");
			end else begin
				want = owed_replies.pop_front();
				check_field("result_code", 32'(want.result_code), 32'(rsp.result_code));
				check_field("found_channel", want.found_channel, rsp.found_channel);
				check_field("found_domain", want.found_domain, rsp.found_domain);
				check_field("found_status", 32'(want.found_status), 32'(rsp.found_status));
				check_field("found_classes", want.found_classes, rsp.found_classes);
				check_field("found_version", want.found_version, rsp.found_version);
				check_field("active_total", 32'(want.active_total), 32'(rsp.active_total));
			end
		end
	end

	// Abort when neither a request nor a reply moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done) quiet = 0;
			else quiet++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		start  <= 1'b0;
		req    <= '0;
		mismatch_count = 0;
		no_gaps        = 1'b0;
		live_count     = 7'd0;
		for (int s = 0; s < SLOTS; s++) begin
			slot_used[s] = 1'b0;
		end
		build_pools();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_table_full();
		test_random_traffic();

		// drain: wait for every owed reply, then let stray ones show up
		start <= 1'b0;
		while (owed_replies.size() != 0) @(posedge clk);
		repeat (SLOTS + 8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/snr_pkg.sv
src/snr_mem.sv
src/snr_ctrl.sv
src/service_name_registry.sv
tb/tb_top.sv
